// File: rtl/sek_pkg.sv
// Shared types and constants for the sparse entry key sort block.
package sek_pkg;

  localparam int FIELD_W = 24;
  localparam int VALUE_W = 64;

  // One incoming sparse entry.
  typedef struct packed {
    logic [FIELD_W-1:0] row_index;
    logic [FIELD_W-1:0] col_index;
    logic [VALUE_W-1:0] entry_value;
    logic               last_entry;
  } entry_t;

  // One sorted entry on the way out.
  typedef struct packed {
    logic [FIELD_W-1:0] sorted_row;
    logic [FIELD_W-1:0] sorted_col;
    logic [VALUE_W-1:0] sorted_value;
    logic               final_result;
    logic               overflowed;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic begin_run;
    logic scan_rd;
    logic emit;
    logic finish;
  } sek_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic emit_last;
  } sek_status_t;

endpackage

// File: rtl/sparse_entry_key_sort.sv
// Top level of the sparse entry key sort block.
// Loading takes one entry per cycle while busy is low; the entry marked last starts the sort.
// With n stored entries each sorted beat follows a scan over all n store entries, so busy
// stays high until the last beat leaves. The single store read port makes a full scan
// necessary for every beat. Results cannot be stalled by the receiver.
// Synchronous reset empties the store, clears the drop flag and sets row-major order.
module sparse_entry_key_sort #(
  parameter int MAX_ENTRIES = 64,
  parameter int INDEX_BITS  = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sek_pkg::entry_t  entry,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  output sek_pkg::result_t result,
  output logic             result_strobe
);
  import sek_pkg::*;

  sek_cmd_t    cmd;
  sek_status_t status;
  logic        accept;

  // Start is only a beat when the block is idle.
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  sek_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .last_entry (entry.last_entry),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  sek_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .entry         (entry),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .status        (status),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule

// File: rtl/sek_datapath.sv
// Entry store, minimum search and output register of the sort block.
module sek_datapath #(
  parameter int MAX_ENTRIES = 64,
  parameter int INDEX_BITS  = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  sek_pkg::entry_t  entry,
  input  logic             cfg_valid,
  input  logic             cfg_data,
  input  sek_pkg::sek_cmd_t cmd,
  output sek_pkg::sek_status_t status,
  output sek_pkg::result_t result,
  output logic             result_strobe
);
  import sek_pkg::*;

  localparam int SW = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int KW = 2 * SW;

  // Entry store.
  logic [SW-1:0]      mem_row [MAX_ENTRIES];
  logic [SW-1:0]      mem_col [MAX_ENTRIES];
  logic [VALUE_W-1:0] mem_val [MAX_ENTRIES];

  logic               key_order;
  logic [CW-1:0]      count;
  logic               drop_flag;
  logic [AW-1:0]      ptr;
  logic [CW-1:0]      emit_cnt;
  logic [MAX_ENTRIES-1:0] emitted;

  // Registered read port.
  logic [SW-1:0]      rd_row;
  logic [SW-1:0]      rd_col;
  logic [VALUE_W-1:0] rd_val;
  logic [AW-1:0]      rd_idx;
  logic               rd_vld;

  // Best candidate of the current scan.
  logic               best_vld;
  logic [KW-1:0]      best_key;
  logic [AW-1:0]      best_idx;
  logic [SW-1:0]      best_row;
  logic [SW-1:0]      best_col;
  logic [VALUE_W-1:0] best_val;

  logic [KW-1:0]      rd_key;
  logic               take;
  logic               store_full;

  assign store_full = (count == CW'(MAX_ENTRIES));

  // Key as selected by the order register.
  assign rd_key = key_order ? {rd_col, rd_row} : {rd_row, rd_col};

  // Strict less keeps the earliest arrival among equal keys.
  assign take = rd_vld && !emitted[rd_idx] && (!best_vld || (rd_key < best_key));

  assign status.scan_last = ((CW'(ptr) + CW'(1)) == count);
  assign status.emit_last = ((emit_cnt + CW'(1)) == count);

  // Configuration register; the port always accepts.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_order <= 1'b0;
    end else if (cfg_valid) begin
      key_order <= cfg_data;
    end
  end

  // Store writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      mem_row[count[AW-1:0]] <= entry.row_index[SW-1:0];
      mem_col[count[AW-1:0]] <= entry.col_index[SW-1:0];
      mem_val[count[AW-1:0]] <= entry.entry_value;
    end
    rd_row <= mem_row[ptr];
    rd_col <= mem_col[ptr];
    rd_val <= mem_val[ptr];
    rd_idx <= ptr;
  end

  // Fill count, drop flag and run control.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      drop_flag <= 1'b0;
      ptr       <= '0;
      emit_cnt  <= '0;
      emitted   <= '0;
      rd_vld    <= 1'b0;
      best_vld  <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
      if (cmd.load) begin
        if (store_full) begin
          drop_flag <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.begin_run) begin
        ptr      <= '0;
        emit_cnt <= '0;
        emitted  <= '0;
        best_vld <= 1'b0;
      end else if (cmd.emit) begin
        ptr               <= '0;
        emit_cnt          <= emit_cnt + CW'(1);
        emitted[best_idx] <= 1'b1;
        best_vld          <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          ptr <= ptr + AW'(1);
        end
        if (take) begin
          best_vld <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count     <= '0;
        drop_flag <= 1'b0;
      end
    end
  end

  // Best candidate payload.
  always_ff @(posedge clk) begin
    if (take) begin
      best_key <= rd_key;
      best_idx <= rd_idx;
      best_row <= rd_row;
      best_col <= rd_col;
      best_val <= rd_val;
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.sorted_row   <= FIELD_W'(best_row);
      result.sorted_col   <= FIELD_W'(best_col);
      result.sorted_value <= best_val;
      result.final_result <= status.emit_last;
      result.overflowed   <= drop_flag;
    end
  end

endmodule

// File: rtl/sek_controller.sv
// Sequencer for loading, scanning and emitting sorted entries.
module sek_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 last_entry,
  input  sek_pkg::sek_status_t status,
  output sek_pkg::sek_cmd_t    cmd,
  output logic                 busy
);
  import sek_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_entry) begin
            cmd.begin_run = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the sparse entry key sort block.
`timescale 1ns / 1ps

module tb;

  import sek_pkg::*;

  localparam int MAX_ENTRIES = 64;
  localparam int INDEX_BITS  = 24;
  localparam int RANDOM_ITEMS = 8;
  localparam int SETTLE_CYCLES = 50;

  // Meaning of the single configuration bit.
  typedef enum logic {
    ROW_MAJOR = 1'b0,
    COL_MAJOR = 1'b1
  } key_order_e;

  // Ways of drawing an index for random entries.
  typedef enum int {
    IDX_NARROW  = 0,
    IDX_WIDE    = 1,
    IDX_EXTREME = 2
  } idx_mode_e;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  entry_t  entry = '0;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_data = 1'b0;
  result_t result;
  logic    result_strobe;

  // Predictor state: entries held for the current set, the drop flag and the order bit.
  entry_t     loaded_entries[$];
  logic       drop_seen = 1'b0;
  key_order_e key_order_now = ROW_MAJOR;

  // Sorted beats still to come, oldest first.
  result_t    sorted_pending[$];

  int mismatches = 0;
  int max_gap = 0;

  sparse_entry_key_sort #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .INDEX_BITS (INDEX_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .entry        (entry),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_strobe(result_strobe)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sort key of one entry under the given order.
  function automatic logic [2*FIELD_W-1:0] entry_key(entry_t e, key_order_e ko);
    if (ko == COL_MAJOR) begin
      return {e.col_index, e.row_index};
    end
    return {e.row_index, e.col_index};
  endfunction

  // Track one accepted entry; on the last one, sort the set stably and queue its beats.
  function automatic void record_entry(entry_t e);
    entry_t  run[$];
    entry_t  tmp;
    result_t beat;
    int      j;
    int      k;
    if (loaded_entries.size() < MAX_ENTRIES) begin
      loaded_entries.push_back(e);
    end else begin
      drop_seen = 1'b1;
    end
    if (!e.last_entry) begin
      return;
    end
    run = loaded_entries;
    // Insertion sort with a strict compare keeps equal keys in arrival order.
    for (k = 1; k < run.size(); k++) begin
      j = k;
      while (j > 0 && entry_key(run[j], key_order_now) < entry_key(run[j-1], key_order_now)) begin
        tmp      = run[j];
        run[j]   = run[j-1];
        run[j-1] = tmp;
        j--;
      end
    end
    for (k = 0; k < run.size(); k++) begin
      beat.sorted_row   = run[k].row_index;
      beat.sorted_col   = run[k].col_index;
      beat.sorted_value = run[k].entry_value;
      beat.final_result = (k == run.size() - 1);
      beat.overflowed   = drop_seen;
      sorted_pending.push_back(beat);
    end
    loaded_entries.delete();
    drop_seen = 1'b0;
  endfunction

  // Draw one index of the requested kind.
  function automatic logic [FIELD_W-1:0] pick_index(idx_mode_e mode);
    case (mode)
      IDX_NARROW:  return FIELD_W'($urandom_range(0, 3));
      IDX_EXTREME: return $urandom_range(0, 1) ? {FIELD_W{1'b1}} : '0;
      default:     return FIELD_W'($urandom);
    endcase
  endfunction

  // Offer one entry after a random gap and wait until the block takes it.
  task automatic send_entry(logic [FIELD_W-1:0] row, logic [FIELD_W-1:0] col,
                            logic [VALUE_W-1:0] value, logic last);
    entry_t e;
    int     gap;
    gap = $urandom_range(0, max_gap);
    e.row_index   = row;
    e.col_index   = col;
    e.entry_value = value;
    e.last_entry  = last;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    entry <= e;
    do @(posedge clk); while (busy);
    record_entry(e);
  endtask

  // Wait until every queued beat has come out, then let the block settle.
  task automatic wait_idle(int settle);
    start <= 1'b0;
    @(posedge clk);
    while (sorted_pending.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write the order bit while no sorted beats are outstanding.
  task automatic write_key_order(key_order_e ko);
    wait_idle(4);
    cfg_valid <= 1'b1;
    cfg_data  <= ko;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_order_now = ko;
  endtask

  // Single-entry sets at both extremes of every field.
  task automatic test_single_entry();
    max_gap = 19;
    send_entry('1, '1, '1, 1'b1);
    send_entry('0, '0, '0, 1'b1);
  endtask

  // The same mixed set sorted under both orders, back to back.
  task automatic test_key_orders();
    key_order_e ko;
    int         n;
    max_gap = 0;
    for (n = 0; n < 2; n++) begin
      ko = (n == 0) ? ROW_MAJOR : COL_MAJOR;
      write_key_order(ko);
      send_entry('1,           24'h000000, 64'h8000_0000_0000_0001, 1'b0);
      send_entry(24'h000000,   '1,         64'h0123_4567_89ab_cdef, 1'b0);
      send_entry(24'h000003,   24'h000001, 64'hffff_0000_ffff_0000, 1'b0);
      send_entry(24'h000003,   24'h000000, 64'h5555_5555_5555_5555, 1'b0);
      send_entry(24'h000000,   24'h000000, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
      send_entry(24'h000001,   24'h800000, 64'h0000_0000_0000_0000, 1'b1);
    end
  endtask

  // Equal keys must come out in arrival order.
  task automatic test_stable_ties();
    max_gap = 3;
    write_key_order(ROW_MAJOR);
    send_entry(24'd5, 24'd2, 64'd1, 1'b0);
    send_entry(24'd5, 24'd2, 64'd2, 1'b0);
    send_entry(24'd1, 24'd9, 64'd3, 1'b0);
    send_entry(24'd5, 24'd2, 64'd4, 1'b1);
  endtask

  // An order change partway through loading applies to the whole set.
  task automatic test_order_change_mid_load();
    max_gap = 19;
    write_key_order(ROW_MAJOR);
    send_entry(24'd2, 24'd0, 64'd10, 1'b0);
    send_entry(24'd0, 24'd7, 64'd11, 1'b0);
    write_key_order(COL_MAJOR);
    send_entry(24'd1, 24'd3, 64'd12, 1'b0);
    send_entry(24'd9, 24'd1, 64'd13, 1'b1);
  endtask

  // Exactly a full store, without any drop.
  task automatic test_full_store();
    int i;
    max_gap = 0;
    write_key_order(COL_MAJOR);
    for (i = 0; i < MAX_ENTRIES; i++) begin
      send_entry(pick_index(IDX_NARROW), pick_index(IDX_NARROW), {$urandom, $urandom},
                 i == MAX_ENTRIES - 1);
    end
  endtask

  // Entries past a full store are dropped, the last one among them; a short set follows.
  task automatic test_overflow();
    int i;
    max_gap = 2;
    write_key_order(ROW_MAJOR);
    for (i = 0; i < MAX_ENTRIES + 3; i++) begin
      send_entry(pick_index(IDX_WIDE), pick_index(IDX_NARROW), {$urandom, $urandom},
                 i == MAX_ENTRIES + 2);
    end
    send_entry(24'd1, 24'd1, 64'd99, 1'b0);
    send_entry(24'd0, 24'd1, 64'd98, 1'b1);
  endtask

  // Random sets: mostly short ones with frequent ties, now and then a long or overflowing one.
  task automatic test_random();
    int        sent;
    int        size;
    int        i;
    idx_mode_e row_mode;
    idx_mode_e col_mode;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        size = $urandom_range(30, MAX_ENTRIES + 6);
      end else begin
        size = $urandom_range(1, 8);
      end
      case ($urandom_range(0, 2))
        0:       max_gap = 0;
        1:       max_gap = 4;
        default: max_gap = 19;
      endcase
      row_mode = idx_mode_e'($urandom_range(0, 2));
      col_mode = idx_mode_e'($urandom_range(0, 2));
      if ($urandom_range(0, 2) == 0) begin
        write_key_order($urandom_range(0, 1) ? COL_MAJOR : ROW_MAJOR);
      end
      for (i = 0; i < size; i++) begin
        // Occasionally flip the order between two entries of a set.
        if (i > 0 && $urandom_range(0, 15) == 0) begin
          write_key_order(key_order_now == ROW_MAJOR ? COL_MAJOR : ROW_MAJOR);
        end
        send_entry(pick_index(row_mode), pick_index(col_mode), {$urandom, $urandom},
                   i == size - 1);
      end
      sent += size;
    end
  endtask

  // Compare each sorted beat with the oldest expectation.
  always @(posedge clk) begin : check_beats
    result_t want;
    if (!rst && result_strobe) begin
      if (sorted_pending.size() == 0) begin
        $error("sorted beat with no entry expected: row %h col %h value %h",
               result.sorted_row, result.sorted_col, result.sorted_value);
        mismatches++;
      end else begin
        want = sorted_pending.pop_front();
        if (result.sorted_row !== want.sorted_row) begin
          $error("sorted_row: expected %h, got %h", want.sorted_row, result.sorted_row);
          mismatches++;
        end
        if (result.sorted_col !== want.sorted_col) begin
          $error("sorted_col: expected %h, got %h", want.sorted_col, result.sorted_col);
          mismatches++;
        end
        if (result.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %h, got %h", want.sorted_value,
                 result.sorted_value);
          mismatches++;
        end
        if (result.final_result !== want.final_result) begin
          $error("final_result: expected %b, got %b", want.final_result,
                 result.final_result);
          mismatches++;
        end
        if (result.overflowed !== want.overflowed) begin
          $error("overflowed: expected %b, got %b", want.overflowed, result.overflowed);
          mismatches++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_entry();
    test_key_orders();
    test_stable_ties();
    test_order_change_mid_load();
    test_full_store();
    test_overflow();
    test_random();
    wait_idle(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("sparse_entry_key_sort: match");
    end else begin
      $display("sparse_entry_key_sort: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake or missing beats.
  initial begin
    #5_000_000;
    $display("sparse_entry_key_sort: mismatch");
    $finish;
  end

endmodule

// File: sim.f
rtl/sek_pkg.sv
rtl/sek_datapath.sv
rtl/sek_controller.sv
rtl/sparse_entry_key_sort.sv
tb/tb.sv
